// File: sv/dosv_pkg.sv
// ----------------------------------------------------------------------------
// dosv_pkg: shared definitions for the override string validator
// Character codes, mode token codes, parse phases and small lookup
// functions used by the byte parser.
// ----------------------------------------------------------------------------
package dosv_pkg;

    // Default limits
    localparam int DEF_MAX_LENGTH = 4096;
    localparam int DEF_MAX_NAME   = 255;

    // Characters with a syntactic role
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_B     = 8'h62;

    // Partial-match position inside "native" / "builtin"
    typedef logic [3:0] tok_t;
    localparam tok_t TOK_NONE    = 4'd0;
    localparam tok_t TOK_N       = 4'd1;
    localparam tok_t TOK_NATIVE  = 4'd6;
    localparam tok_t TOK_B       = 4'd7;
    localparam tok_t TOK_BUILTIN = 4'd13;

    // Mode classes, one bit each
    typedef logic [1:0] mode_set_t;
    localparam mode_set_t MODE_NONE    = 2'b00;
    localparam mode_set_t MODE_NATIVE  = 2'b01;
    localparam mode_set_t MODE_BUILTIN = 2'b10;

    // Parse phases, one-hot
    typedef enum logic [6:0] {
        PH_NAME_PRE   = 7'b0000001,
        PH_NAME       = 7'b0000010,
        PH_NAME_POST  = 7'b0000100,
        PH_MODE_PRE   = 7'b0001000,
        PH_MODE_COMMA = 7'b0010000,
        PH_MODE       = 7'b0100000,
        PH_MODE_POST  = 7'b1000000
    } phase_t;

    // Next character that extends a partial mode match; zero where none does
    function automatic logic [7:0] tok_next_char(tok_t t);
        case (t)
            4'd1:    return "a";
            4'd2:    return "t";
            4'd3:    return "i";
            4'd4:    return "v";
            4'd5:    return "e";
            4'd7:    return "u";
            4'd8:    return "i";
            4'd9:    return "l";
            4'd10:   return "t";
            4'd11:   return "i";
            4'd12:   return "n";
            default: return 8'h00;
        endcase
    endfunction

    // Mode class of a finished token
    function automatic mode_set_t mode_class(tok_t t);
        if (t == TOK_N || t == TOK_NATIVE)
            return MODE_NATIVE;
        else if (t == TOK_B || t == TOK_BUILTIN)
            return MODE_BUILTIN;
        else
            return MODE_NONE;
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return (c >= "a") && (c <= "z");
    endfunction

    function automatic logic is_module_char(logic [7:0] c);
        return is_lower(c) || ((c >= "A") && (c <= "Z")) || ((c >= "0") && (c <= "9")) ||
               (c == "_") || (c == "-") || (c == ".") || (c == "*");
    endfunction

endpackage

// File: sv/dll_override_string_validator.sv
// ----------------------------------------------------------------------------
// dll_override_string_validator: library override string syntax checker
// Parses an override string one byte per request and returns one validity
// flag per string on its final byte or on an empty-string request.
// ----------------------------------------------------------------------------
// Takes one byte in every cycle with no bubbles between strings unless the
// input is held as below. Each request lands in an input register; the parse
// state update and the end-of-string check are one shallow step from there
// into the result register, which presents the flag for a string once its
// final byte has moved on from the input register, and holds it until the
// output side is ready. A result waiting to be taken does not stop non-final
// bytes; only a second result behind a stalled one holds the input.
// A name longer than MAX_NAME, a string longer than MAX_LENGTH, a trailing
// comma or semicolon and an unknown or repeated mode all give a 0 flag.
// An empty-string request always gives 1 and drops any partial string.
module dll_override_string_validator
    import dosv_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int MAX_NAME   = DEF_MAX_NAME
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // final_byte
    input  logic       s_axis_tuser,   // empty_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] string_valid, [7:1] zero
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 2);
    localparam int LEN_W = $clog2(MAX_NAME + 2);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // Parse state
    phase_t     phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    tok_t       tok_reg, tok_next;
    mode_set_t  seen_reg, seen_next;
    logic       err_reg, err_next;

    // Result register
    logic       out_valid_reg;
    logic       out_flag_reg;

    logic       advance;
    logic       in_done;
    logic       sp;
    logic       name_post;
    logic       mode_post;
    mode_set_t  cls;
    mode_set_t  end_cls;
    logic [7:0] tok_char;
    logic       end_ok;
    logic       result_ok;

    // Handshake: the input register moves on unless a result is blocked
    assign in_done       = in_last_reg || in_empty_reg;
    assign advance       = in_valid_reg && (!in_done || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
    end

    assign sp       = (in_byte_reg == CH_SPACE);
    assign cls      = mode_class(tok_reg);
    assign tok_char = tok_next_char(tok_reg);

    // Byte count saturates one past the limit
    assign cnt_next = (cnt_reg <= CNT_W'(MAX_LENGTH)) ? cnt_reg + 1'b1 : cnt_reg;

    // Per-byte parse step
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        tok_next   = tok_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        name_post  = 1'b0;
        mode_post  = 1'b0;
        if (!err_reg)
        begin
            case (phase_reg)
                PH_NAME_PRE:
                begin
                    if (!sp)
                    begin
                        if (is_module_char(in_byte_reg))
                        begin
                            phase_next = PH_NAME;
                            len_next   = LEN_W'(1);
                        end
                        else
                            err_next = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    if (is_module_char(in_byte_reg))
                    begin
                        if (len_reg >= LEN_W'(MAX_NAME))
                            err_next = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    else
                        name_post = 1'b1;
                end
                PH_NAME_POST:
                    name_post = 1'b1;
                PH_MODE_PRE, PH_MODE_COMMA:
                begin
                    if (!sp)
                    begin
                        if (is_lower(in_byte_reg))
                        begin
                            phase_next = PH_MODE;
                            if (in_byte_reg == CH_N)
                                tok_next = TOK_N;
                            else if (in_byte_reg == CH_B)
                                tok_next = TOK_B;
                            else
                                tok_next = TOK_NONE;
                        end
                        else if (in_byte_reg == CH_SEMI && phase_reg == PH_MODE_PRE)
                            phase_next = PH_NAME_PRE;
                        else
                            err_next = 1'b1;
                    end
                end
                PH_MODE:
                begin
                    if (is_lower(in_byte_reg))
                    begin
                        if (tok_char != 8'h00 && tok_char == in_byte_reg)
                            tok_next = tok_reg + 1'b1;
                        else
                            tok_next = TOK_NONE;
                    end
                    else
                    begin
                        // mode token ended: classify, then treat byte as separator
                        tok_next = TOK_NONE;
                        if (cls == MODE_NONE || (seen_reg & cls) != MODE_NONE)
                            err_next = 1'b1;
                        else
                        begin
                            seen_next = seen_reg | cls;
                            mode_post = 1'b1;
                        end
                    end
                end
                PH_MODE_POST:
                    mode_post = 1'b1;
                default:
                    err_next = 1'b1;
            endcase

            // separator after a module name
            if (name_post)
            begin
                if (sp)
                    phase_next = PH_NAME_POST;
                else if (in_byte_reg == CH_COMMA)
                    phase_next = PH_NAME_PRE;
                else if (in_byte_reg == CH_EQUAL)
                begin
                    phase_next = PH_MODE_PRE;
                    seen_next  = MODE_NONE;
                end
                else
                    err_next = 1'b1;
            end

            // separator after a mode
            if (mode_post)
            begin
                if (sp)
                    phase_next = PH_MODE_POST;
                else if (in_byte_reg == CH_COMMA)
                    phase_next = PH_MODE_COMMA;
                else if (in_byte_reg == CH_SEMI)
                    phase_next = PH_NAME_PRE;
                else
                    err_next = 1'b1;
            end
        end
    end

    // End-of-string check on the updated state
    assign end_cls = mode_class(tok_next);

    always_comb
    begin
        case (phase_next)
            PH_MODE_PRE, PH_MODE_POST:
                end_ok = 1'b1;
            PH_MODE:
                end_ok = (end_cls != MODE_NONE) && ((seen_next & end_cls) == MODE_NONE);
            default:
                end_ok = 1'b0;
        endcase
    end

    assign result_ok = !err_next && (cnt_next <= CNT_W'(MAX_LENGTH)) && end_ok;

    // Parse state registers; a finished string returns to the start state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME_PRE;
            len_reg   <= '0;
            cnt_reg   <= '0;
            tok_reg   <= TOK_NONE;
            seen_reg  <= MODE_NONE;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (in_done)
            begin
                phase_reg <= PH_NAME_PRE;
                len_reg   <= '0;
                cnt_reg   <= '0;
                tok_reg   <= TOK_NONE;
                seen_reg  <= MODE_NONE;
                err_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                cnt_reg   <= cnt_next;
                tok_reg   <= tok_next;
                seen_reg  <= seen_next;
                err_reg   <= err_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_done)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_done)
            out_flag_reg <= in_empty_reg || result_ok;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_flag_reg};

endmodule

// File: sv/dosv_checker.sv
// ----------------------------------------------------------------------------
// dosv_checker: port-level checks for the override string validator
// Watches the stream ports for result timing, stall behaviour, empty-string results and result padding.
// ----------------------------------------------------------------------------
module dosv_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic       s_axis_tlast,   // final_byte
    input  logic       s_axis_tuser,   // empty_string
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata    // [0] string_valid, [7:1] zero
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input is never held off while no result is pending
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // A fresh result follows an accepted final or empty request
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_acc && (s_axis_tlast || s_axis_tuser), 2))
        else $error("result without a terminating request");

    // Empty string always reports valid
    a_empty_ok: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && $past(s_acc && s_axis_tuser, 2) |-> m_axis_tdata[0])
        else $error("empty string reported invalid");

    // Padding bits of a result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0000000))
        else $error("result padding bits not zero");

endmodule

bind dll_override_string_validator dosv_checker u_dosv_checker (.*);

// File: tb/dll_override_string_validator_tb.sv
// ----------------------------------------------------------------------------
// dll_override_string_validator_tb: self-checking bench for the validator
// Streams directed and random override strings one byte per request, keeps
// its own parse state to predict each string's validity flag, and compares
// every returned flag in order while both stream sides stall at random, and in a last run without stalls.
// ----------------------------------------------------------------------------
module dll_override_string_validator_tb;
    import dosv_pkg::*;

    localparam int STR_LIMIT   = DEF_MAX_LENGTH;
    localparam int NAME_LIMIT  = DEF_MAX_NAME;
    localparam int QUIET_LIMIT = 2000;

    // Predicts the validity flag of each string from the accepted requests
    class override_syntax_tracker;
        phase_t      phase;
        int unsigned name_len;
        int unsigned byte_cnt;
        tok_t        tok;
        mode_set_t   modes;
        bit          bad;
        bit          pending_flags[$];
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase    = PH_NAME_PRE;
            name_len = 0;
            byte_cnt = 0;
            tok      = TOK_NONE;
            modes    = MODE_NONE;
            bad      = 1'b0;
        endfunction

        static function bit name_char(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || c == "_" || c == "-" || c == "." || c == "*";
        endfunction

        static function bit lower_letter(logic [7:0] c);
            return c >= "a" && c <= "z";
        endfunction

        // Letter that extends the partial mode word, zero if nothing does
        function logic [7:0] follow_char();
            string nat;
            string blt;
            nat = "native";
            blt = "builtin";
            if (tok >= TOK_N && tok < TOK_NATIVE)
                return nat[tok];
            if (tok >= TOK_B && tok < TOK_BUILTIN)
                return blt[tok - TOK_B + 1];
            return 8'h00;
        endfunction

        // Ends a mode word; false for an unknown word or a repeated class
        function bit close_mode();
            mode_set_t cls;
            cls = MODE_NONE;
            if (tok == TOK_N || tok == TOK_NATIVE)
                cls = MODE_NATIVE;
            else if (tok == TOK_B || tok == TOK_BUILTIN)
                cls = MODE_BUILTIN;
            tok = TOK_NONE;
            if (cls == MODE_NONE || (modes & cls) != MODE_NONE)
                return 1'b0;
            modes = modes | cls;
            return 1'b1;
        endfunction

        function void after_name(logic [7:0] c);
            if (c == CH_SPACE)
                phase = PH_NAME_POST;
            else if (c == CH_COMMA)
                phase = PH_NAME_PRE;
            else if (c == CH_EQUAL)
            begin
                phase = PH_MODE_PRE;
                modes = MODE_NONE;
            end
            else
                bad = 1'b1;
        endfunction

        function void after_mode(logic [7:0] c);
            if (c == CH_SPACE)
                phase = PH_MODE_POST;
            else if (c == CH_COMMA)
                phase = PH_MODE_COMMA;
            else if (c == CH_SEMI)
                phase = PH_NAME_PRE;
            else
                bad = 1'b1;
        endfunction

        function void parse(logic [7:0] c);
            logic [7:0] nxt;
            case (phase)
                PH_NAME_PRE:
                    if (c != CH_SPACE)
                    begin
                        if (name_char(c))
                        begin
                            phase    = PH_NAME;
                            name_len = 1;
                            if (name_len > NAME_LIMIT)
                                bad = 1'b1;
                        end
                        else
                            bad = 1'b1;
                    end
                PH_NAME:
                    if (name_char(c))
                    begin
                        if (name_len <= NAME_LIMIT)
                            name_len++;
                        if (name_len > NAME_LIMIT)
                            bad = 1'b1;
                    end
                    else
                        after_name(c);
                PH_NAME_POST:
                    after_name(c);
                PH_MODE_PRE, PH_MODE_COMMA:
                    if (c != CH_SPACE)
                    begin
                        if (lower_letter(c))
                        begin
                            tok   = (c == CH_N) ? TOK_N : (c == CH_B) ? TOK_B : TOK_NONE;
                            phase = PH_MODE;
                        end
                        else if (c == CH_SEMI && phase == PH_MODE_PRE)
                            phase = PH_NAME_PRE;
                        else
                            bad = 1'b1;
                    end
                PH_MODE:
                    if (lower_letter(c))
                    begin
                        nxt = follow_char();
                        if (nxt != 8'h00 && nxt == c)
                            tok = tok + 1'b1;
                        else
                            tok = TOK_NONE;
                    end
                    else if (!close_mode())
                        bad = 1'b1;
                    else
                        after_mode(c);
                PH_MODE_POST:
                    after_mode(c);
                default:
                    bad = 1'b1;
            endcase
        endfunction

        // String may end only after '=' or after a complete mode
        function bit string_closed();
            case (phase)
                PH_MODE_PRE, PH_MODE_POST: return 1'b1;
                PH_MODE:                   return close_mode();
                default:                   return 1'b0;
            endcase
        endfunction

        function void take_request(logic [7:0] c, logic last, logic empty);
            bit ok;
            if (empty)
            begin
                restart();
                pending_flags.push_back(1'b1);
                return;
            end
            if (byte_cnt <= STR_LIMIT)
                byte_cnt++;
            if (!bad)
                parse(c);
            if (last)
            begin
                ok = !bad && byte_cnt <= STR_LIMIT && string_closed();
                pending_flags.push_back(ok);
                restart();
            end
        endfunction

        function void check_flag(logic [7:0] data);
            logic [7:0] want;
            if (pending_flags.size() == 0)
            begin
                $display("%0t: result %h arrived with no string pending", $time, data);
                mismatches++;
                return;
            end
            want = {7'd0, pending_flags.pop_front()};
            if (data !== want)
            begin
                $display("%0t: string_valid mismatch: expected %h, actual %h",
                         $time, want, data);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    override_syntax_tracker sb = new();
    logic [7:0] text[$];
    int         send_idle_pct = 15;
    int         recv_idle_pct = 61;
    int         requests_sent = 0;
    int         quiet_cycles  = 0;

    dll_override_string_validator #(
        .MAX_LENGTH (STR_LIMIT),
        .MAX_NAME   (NAME_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Monitor both sides, drive sink stalls, watch for a hang
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_request(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_flag(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One request, after a random gap; returns at the accepting edge
    task automatic send_request(input logic [7:0] c, input logic last, input logic empty);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_request(text[i], i == text.size() - 1, 1'b0);
    endtask

    // Source holds off until every flag is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_flags.size() != 0)
            @(posedge clk);
    endtask

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    task automatic check_str(input string s);
        text.delete();
        put_str(s);
        send_text();
    endtask

    function automatic void put_pad();
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) text.push_back(CH_SPACE);
    endfunction

    // Mostly a correct mode of the given class, sometimes a wrong word or class
    function automatic void put_mode(input bit native);
        string bad_words[7];
        int    r;
        bad_words = '{"nativ", "natives", "bu", "builtinx", "x", "nb", "Native"};
        r = $urandom_range(19);
        if (r == 0)
            put_str(bad_words[$urandom_range(6)]);
        else
        begin
            if (r == 1)
                native = !native;
            if (native)
            begin
                if ($urandom_range(1))
                    put_str("n");
                else
                    put_str("native");
            end
            else
            begin
                if ($urandom_range(1))
                    put_str("b");
                else
                    put_str("builtin");
            end
        end
    endfunction

    function automatic void build_override();
        string charset;
        int    n_entries;
        int    n_names;
        int    n_modes;
        int    len;
        bit    first_native;
        charset = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.*";
        text.delete();
        n_entries = $urandom_range(1, 3);
        for (int e = 0; e < n_entries; e++)
        begin
            if (e > 0)
            begin
                put_pad();
                text.push_back(CH_SEMI);
            end
            n_names = $urandom_range(1, 3);
            for (int k = 0; k < n_names; k++)
            begin
                if (k > 0)
                    text.push_back(CH_COMMA);
                put_pad();
                // rare names near the length limit
                len = ($urandom_range(99) == 0) ? $urandom_range(NAME_LIMIT - 3, NAME_LIMIT + 2)
                                                : $urandom_range(1, 8);
                repeat (len) text.push_back(charset[$urandom_range(charset.len() - 1)]);
                put_pad();
            end
            text.push_back(CH_EQUAL);
            put_pad();
            n_modes      = $urandom_range(0, 2);
            first_native = 1'($urandom_range(1));
            for (int k = 0; k < n_modes; k++)
            begin
                if (k > 0)
                begin
                    put_pad();
                    text.push_back(CH_COMMA);
                    put_pad();
                end
                put_mode((k == 0) == first_native);
            end
            put_pad();
        end
    endfunction

    // Break a generated string in one place
    function automatic void mutate();
        string syntax_chars;
        int    pos;
        syntax_chars = ",;= nb";
        pos = $urandom_range(text.size() - 1);
        case ($urandom_range(5))
            0: text[pos] = 8'($urandom_range(255));
            1: text[pos] = syntax_chars[$urandom_range(syntax_chars.len() - 1)];
            2: if (text.size() > 1) text.delete(pos);
            3: text.push_back(CH_COMMA);
            4: text.push_back(CH_SEMI);
            default: text = text[0:pos];
        endcase
    endfunction

    task automatic random_strings(input int count);
        int goal;
        int r;
        int half;
        goal = requests_sent + count;
        while (requests_sent < goal)
        begin
            r = $urandom_range(99);
            if (r < 5)
                send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            else if (r < 8)
            begin
                // partial string dropped by an empty-string request
                build_override();
                half = text.size() / 2;
                for (int i = 0; i < half; i++)
                    send_request(text[i], 1'b0, 1'b0);
                send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            end
            else if (r < 18)
            begin
                text.delete();
                repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
                send_text();
            end
            else
            begin
                build_override();
                if ($urandom_range(99) < 35)
                    mutate();
                send_text();
            end
        end
    endtask

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Directed strings
        check_str("a=");
        check_str("a=n");
        check_str("*.dll, x-y_z.Q = native , b ;k=builtin");
        check_str("  a = n, b  ");
        check_str("a=native,builtin");
        check_str("a=n,native");
        check_str("a=b, builtin");
        check_str("a=nat");
        check_str("a=n,");
        check_str("a=n;");
        check_str("   ");
        check_str("a");
        check_str("a=N");
        check_str("a=;b=");
        check_str("a==");
        check_str(",a=");
        check_str("a,,b=");
        text.delete();
        put_str("a");
        text.push_back(8'h80);
        put_str("=n");
        send_text();
        text = '{8'hFF};
        send_text();
        // empty string, alone and with the final mark set
        send_request(8'h41, 1'b0, 1'b1);
        send_request(8'hBE, 1'b1, 1'b1);
        // partial string then empty string
        for (int i = 0; i < 3; i++)
            send_request("x", 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        // longest legal name, then one longer
        text.delete();
        repeat (NAME_LIMIT) text.push_back("q");
        put_str("=n");
        send_text();
        text.delete();
        repeat (NAME_LIMIT + 1) text.push_back("q");
        put_str("=n");
        send_text();
        wait_drained();

        // Random strings under three stall mixes
        random_strings(450);
        wait_drained();
        send_idle_pct = 61;
        recv_idle_pct = 15;
        random_strings(450);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_strings(350);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_flags.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
sv/dosv_pkg.sv
sv/dll_override_string_validator.sv
sv/dosv_checker.sv
tb/dll_override_string_validator_tb.sv
